FILE: design/tdau_pkg.sv
// ----------------------------------------------------------------------------
// tdau_pkg
// Types, constants and step functions shared by the time of day unit.
// ----------------------------------------------------------------------------
package tdau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_DIV = 2'd2,
        OP_MID = 2'd3
    } t_op;

    localparam int NST    = 8;
    localparam int A_LAST = 2;
    localparam int AW     = 10;
    localparam int BW     = 18;

    localparam logic [10:0] MS_RADIX  = 11'd1000;
    localparam logic [6:0]  SEC_RADIX = 7'd60;
    localparam logic [5:0]  HR_RADIX  = 6'd24;

    localparam int A_STEPS [NST] = '{4, 4, 2, 0, 0, 0, 0, 0};
    localparam int B_STEPS [NST] = '{0, 0, 0, 4, 4, 4, 4, 2};

    typedef struct packed {
        logic [9:0] ms;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
    } t_tod;

    typedef struct packed {
        t_op        op;
        logic [7:0] kdiv;
        t_tod       a;
        t_tod       b;
    } t_in;

    typedef struct packed {
        t_op                   op;
        logic [7:0]            kdiv;
        t_tod                  res;
        logic [3:0][7:0]       a_rem;
        logic [3:0][AW-1:0]    a_num;
        logic [2:0][7:0]       b_rem;
        logic [2:0][BW-1:0]    b_num;
    } t_stg;

    function automatic t_tod tod_add(t_tod x, t_tod y);
        t_tod       r;
        logic [10:0] s_ms;
        logic [6:0]  s_sm;
        logic [5:0]  s_hr;
        logic        c;
        s_ms = {1'b0, x.ms} + {1'b0, y.ms};
        c = 1'b0;
        if (s_ms >= 2 * MS_RADIX) begin
            s_ms = 11'(s_ms - 2 * MS_RADIX);
            c = 1'b1;
        end else if (s_ms >= MS_RADIX) begin
            s_ms = s_ms - MS_RADIX;
            c = 1'b1;
        end
        r.ms = s_ms[9:0];
        s_sm = {1'b0, x.sec} + {1'b0, y.sec} + {6'd0, c};
        c = 1'b0;
        if (s_sm >= 2 * SEC_RADIX) begin
            s_sm = 7'(s_sm - 2 * SEC_RADIX);
            c = 1'b1;
        end else if (s_sm >= SEC_RADIX) begin
            s_sm = s_sm - SEC_RADIX;
            c = 1'b1;
        end
        r.sec = s_sm[5:0];
        s_sm = {1'b0, x.min} + {1'b0, y.min} + {6'd0, c};
        c = 1'b0;
        if (s_sm >= 2 * SEC_RADIX) begin
            s_sm = 7'(s_sm - 2 * SEC_RADIX);
            c = 1'b1;
        end else if (s_sm >= SEC_RADIX) begin
            s_sm = s_sm - SEC_RADIX;
            c = 1'b1;
        end
        r.min = s_sm[5:0];
        s_hr = {1'b0, x.hr} + {1'b0, y.hr} + {5'd0, c};
        if (s_hr >= 2 * HR_RADIX) begin
            s_hr = 6'(s_hr - 2 * HR_RADIX);
        end else if (s_hr >= HR_RADIX) begin
            s_hr = s_hr - HR_RADIX;
        end
        r.hr = s_hr[4:0];
        return r;
    endfunction

    function automatic t_tod tod_sub(t_tod x, t_tod y);
        t_tod        r;
        logic [11:0] d_ms;
        logic [7:0]  d_sm;
        logic [6:0]  d_hr;
        logic        bw;
        d_ms = {2'b0, x.ms} - {2'b0, y.ms};
        bw = d_ms[11];
        if (bw) begin
            d_ms = d_ms + {1'b0, MS_RADIX};
        end
        r.ms = d_ms[9:0];
        d_sm = {2'b0, x.sec} - {2'b0, y.sec} - {7'd0, bw};
        bw = d_sm[7];
        if (bw) begin
            d_sm = d_sm + {1'b0, SEC_RADIX};
        end
        r.sec = d_sm[5:0];
        d_sm = {2'b0, x.min} - {2'b0, y.min} - {7'd0, bw};
        bw = d_sm[7];
        if (bw) begin
            d_sm = d_sm + {1'b0, SEC_RADIX};
        end
        r.min = d_sm[5:0];
        d_hr = {2'b0, x.hr} - {2'b0, y.hr} - {6'd0, bw};
        if (d_hr[6]) begin
            d_hr = d_hr + {1'b0, HR_RADIX};
        end
        r.hr = d_hr[4:0];
        return r;
    endfunction

    function automatic t_tod tod_half(t_tod x);
        t_tod r;
        r.ms  = {1'b0, x.ms[9:1]} + (x.sec[0] ? 10'd500 : 10'd0);
        r.sec = {1'b0, x.sec[5:1]} + (x.min[0] ? 6'd30 : 6'd0);
        r.min = {1'b0, x.min[5:1]} + (x.hr[0] ? 6'd30 : 6'd0);
        r.hr  = {1'b0, x.hr[4:1]};
        return r;
    endfunction

    function automatic t_stg a_steps(t_stg s, int n);
        t_stg       r;
        logic [8:0] t;
        r = s;
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                for (int l = 0; l < 4; l++) begin
                    t = {r.a_rem[l], r.a_num[l][AW-1]};
                    if (t >= {1'b0, r.kdiv}) begin
                        t = t - {1'b0, r.kdiv};
                        r.a_num[l] = {r.a_num[l][AW-2:0], 1'b1};
                    end else begin
                        r.a_num[l] = {r.a_num[l][AW-2:0], 1'b0};
                    end
                    r.a_rem[l] = t[7:0];
                end
            end
        end
        return r;
    endfunction

    function automatic t_stg b_steps(t_stg s, int n);
        t_stg       r;
        logic [8:0] t;
        r = s;
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                for (int l = 0; l < 3; l++) begin
                    t = {r.b_rem[l], r.b_num[l][BW-1]};
                    if (t >= {1'b0, r.kdiv}) begin
                        t = t - {1'b0, r.kdiv};
                        r.b_num[l] = {r.b_num[l][BW-2:0], 1'b1};
                    end else begin
                        r.b_num[l] = {r.b_num[l][BW-2:0], 1'b0};
                    end
                    r.b_rem[l] = t[7:0];
                end
            end
        end
        return r;
    endfunction

endpackage

FILE: design/time_of_day_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// time_of_day_arithmetic_unit
// Pipelined add, subtract, divide and middle on two times of day.
// ----------------------------------------------------------------------------
// Operands arrive on the slave stream: tuser carries the opcode and tdata the
// two times and the divisor. Each transfer gives exactly one result transfer
// on the master stream: tdata carries the result time, tuser the divide
// error flag.
// The unit is a ten stage pipeline: an input register, eight stages of a
// restoring divider with two to four quotient bits per stage (first on
// the time fields, then on the remainders scaled by the radix), and an
// output register. One operation is taken every cycle while the receiver
// does not stall the output.
// Add, subtract and middle are computed in the first stages and carried
// along with the divider lanes, so every opcode has the same latency.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and tready on the slave side drops; nothing is lost or repeated.
// Reset clears all valid bits and holds tready low; the block takes
// operands in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module time_of_day_arithmetic_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // a_millis, a_seconds, a_minutes, a_hours, b_millis, b_seconds,
    // b_minutes, b_hours, divisor, zero fill
    input  logic [63:0] s_axis_tdata,
    // opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // r_millis, r_seconds, r_minutes, r_hours, zero fill
    output logic [31:0] m_axis_tdata,
    // divide_error
    output logic        m_axis_tuser
);

    logic                       w_en;
    tdau_pkg::t_in              r_in;
    logic                       r_vin;
    tdau_pkg::t_stg             r_st [tdau_pkg::NST];
    tdau_pkg::t_stg             n_st [tdau_pkg::NST];
    logic [tdau_pkg::NST-1:0]   r_vst;
    tdau_pkg::t_tod             r_out;
    logic                       r_err;
    logic                       r_vout;
    tdau_pkg::t_tod             n_out;
    logic                       n_err;

    assign w_en          = ~r_vout | m_axis_tready;
    assign s_axis_tready = w_en & i_rst_n;

    always_comb begin
        tdau_pkg::t_stg t;
        t.op       = r_in.op;
        t.kdiv     = r_in.kdiv;
        if (r_in.op == tdau_pkg::OP_SUB) begin
            t.res = tdau_pkg::tod_sub(r_in.a, r_in.b);
        end else begin
            t.res = tdau_pkg::tod_add(r_in.a, r_in.b);
        end
        t.a_rem    = '0;
        t.a_num[0] = r_in.a.ms;
        t.a_num[1] = {4'd0, r_in.a.sec};
        t.a_num[2] = {4'd0, r_in.a.min};
        t.a_num[3] = {5'd0, r_in.a.hr};
        t.b_rem    = '0;
        t.b_num    = '0;
        n_st[0]    = tdau_pkg::a_steps(t, tdau_pkg::A_STEPS[0]);
        for (int j = 1; j < tdau_pkg::NST; j++) begin
            t = r_st[j-1];
            if (j == 1 && t.op == tdau_pkg::OP_MID) begin
                t.res = tdau_pkg::tod_half(t.res);
            end
            t = tdau_pkg::a_steps(t, tdau_pkg::A_STEPS[j]);
            if (j == tdau_pkg::A_LAST) begin
                t.b_rem    = '0;
                t.b_num[0] = 18'({t.a_rem[1], 10'd0} - {t.a_rem[1], 4'd0}
                                 - {t.a_rem[1], 3'd0});
                t.b_num[1] = 18'({t.a_rem[2], 6'd0} - {t.a_rem[2], 2'd0});
                t.b_num[2] = 18'({t.a_rem[3], 6'd0} - {t.a_rem[3], 2'd0});
            end
            n_st[j] = tdau_pkg::b_steps(t, tdau_pkg::B_STEPS[j]);
        end
    end

    always_comb begin
        tdau_pkg::t_stg l;
        l     = r_st[tdau_pkg::NST-1];
        n_out = l.res;
        n_err = 1'b0;
        if (l.op == tdau_pkg::OP_DIV) begin
            if (l.kdiv == 8'd0) begin
                n_out = '0;
                n_err = 1'b1;
            end else begin
                n_out.ms  = 10'(l.a_num[0] + l.b_num[0][9:0]);
                n_out.sec = 6'(l.a_num[1][5:0] + l.b_num[1][5:0]);
                n_out.min = 6'(l.a_num[2][5:0] + l.b_num[2][5:0]);
                n_out.hr  = l.a_num[3][4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vin  <= 1'b0;
            r_vst  <= '0;
            r_vout <= 1'b0;
        end else if (w_en) begin
            r_vin  <= s_axis_tvalid;
            r_vst  <= {r_vst[tdau_pkg::NST-2:0], r_vin};
            r_vout <= r_vst[tdau_pkg::NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in.op   <= tdau_pkg::t_op'(s_axis_tuser);
            r_in.a.ms  <= s_axis_tdata[9:0];
            r_in.a.sec <= s_axis_tdata[15:10];
            r_in.a.min <= s_axis_tdata[21:16];
            r_in.a.hr  <= s_axis_tdata[26:22];
            r_in.b.ms  <= s_axis_tdata[36:27];
            r_in.b.sec <= s_axis_tdata[42:37];
            r_in.b.min <= s_axis_tdata[48:43];
            r_in.b.hr  <= s_axis_tdata[53:49];
            r_in.kdiv  <= s_axis_tdata[61:54];
            for (int j = 0; j < tdau_pkg::NST; j++) begin
                r_st[j] <= n_st[j];
            end
            r_out <= n_out;
            r_err <= n_err;
        end
    end

    assign m_axis_tvalid = r_vout;
    assign m_axis_tdata  = {5'd0, r_out.hr, r_out.min, r_out.sec, r_out.ms};
    assign m_axis_tuser  = r_err;

endmodule

FILE: design/tdau_chk.sv
// ----------------------------------------------------------------------------
// tdau_chk
// Port level checks for the time of day unit, bound to the top level.
// ----------------------------------------------------------------------------
module tdau_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("Stalled result changed.");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("Input not ready while the output can move.");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("Input ready while the pipeline is stalled.");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
        else $error("Divide error with a nonzero time.");

endmodule

bind time_of_day_arithmetic_unit tdau_chk u_tdau_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the time of day unit against a predictor of add, subtract, divide
// and middle, with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [9:0] ms;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
        logic       err;
    } t_tod_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    t_tod_res    pending_times[$];
    int          mismatches = 0;
    bit          hold_output;
    int          rx_wait;
    event        hold_go;

    time_of_day_arithmetic_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic t_tod_res tod_plus(longint am, longint as_, longint an, longint ah,
                                          longint bm, longint bs, longint bn, longint bh);
        t_tod_res r;
        longint s;
        longint c;
        s = am + bm; c = 0;
        if (s >= 1000) begin s = s % 1000; c = 1; end
        r.ms = s[9:0];
        s = as_ + bs + c; c = 0;
        if (s >= 60) begin s = s % 60; c = 1; end
        r.sec = s[5:0];
        s = an + bn + c; c = 0;
        if (s >= 60) begin s = s % 60; c = 1; end
        r.min = s[5:0];
        s = (ah + bh + c) % 24;
        r.hr = s[4:0];
        r.err = 1'b0;
        return r;
    endfunction

    function automatic t_tod_res tod_divided(longint m, longint s, longint n, longint h,
                                             longint k);
        t_tod_res r;
        longint v;
        v = m / k + ((s % k) * 1000) / k; r.ms = v[9:0];
        v = s / k + ((n % k) * 60) / k;   r.sec = v[5:0];
        v = n / k + ((h % k) * 60) / k;   r.min = v[5:0];
        v = h / k;                        r.hr = v[4:0];
        r.err = 1'b0;
        return r;
    endfunction

    function automatic t_tod_res predict_time(tdau_pkg::t_op op, tdau_pkg::t_tod a,
                                              tdau_pkg::t_tod b, logic [7:0] k);
        t_tod_res r;
        longint d;
        longint bw;
        case (op)
            tdau_pkg::OP_ADD: begin
                r = tod_plus(a.ms, a.sec, a.min, a.hr, b.ms, b.sec, b.min, b.hr);
            end
            tdau_pkg::OP_SUB: begin
                d = longint'(a.ms) - b.ms; bw = 0;
                if (d < 0) begin d += 1000; bw = 1; end
                r.ms = d[9:0];
                d = longint'(a.sec) - b.sec - bw; bw = 0;
                if (d < 0) begin d += 60; bw = 1; end
                r.sec = d[5:0];
                d = longint'(a.min) - b.min - bw; bw = 0;
                if (d < 0) begin d += 60; bw = 1; end
                r.min = d[5:0];
                d = longint'(a.hr) - b.hr - bw;
                if (d < 0) d += 24;
                r.hr = d[4:0];
                r.err = 1'b0;
            end
            tdau_pkg::OP_DIV: begin
                if (k == 8'd0) begin
                    r = '{10'd0, 6'd0, 6'd0, 5'd0, 1'b1};
                end else begin
                    r = tod_divided(a.ms, a.sec, a.min, a.hr, k);
                end
            end
            default: begin
                r = tod_plus(a.ms, a.sec, a.min, a.hr, b.ms, b.sec, b.min, b.hr);
                r = tod_divided(r.ms, r.sec, r.min, r.hr, 2);
            end
        endcase
        return r;
    endfunction

    task automatic send_operation(tdau_pkg::t_op op, tdau_pkg::t_tod a, tdau_pkg::t_tod b,
                                  logic [7:0] k);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'd0, k, b.hr, b.min, b.sec, b.ms, a.hr, a.min, a.sec, a.ms};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_times.push_back(predict_time(op, a, b, k));
    endtask

    function automatic tdau_pkg::t_tod any_time(bit legal);
        tdau_pkg::t_tod t;
        if (legal) begin
            t.ms = 10'($urandom_range(0, 999));
            t.sec = 6'($urandom_range(0, 59));
            t.min = 6'($urandom_range(0, 59));
            t.hr = 5'($urandom_range(0, 23));
        end else begin
            t = 27'($urandom);
        end
        return t;
    endfunction

    function automatic logic [7:0] any_divisor();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            3: return 8'($urandom_range(2, 8));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_directed_extremes();
        tdau_pkg::t_tod zero;
        tdau_pkg::t_tod top;
        tdau_pkg::t_tod full;
        zero = '{10'd0, 6'd0, 6'd0, 5'd0};
        top  = '{10'd999, 6'd59, 6'd59, 5'd23};
        full = '{10'h3FF, 6'h3F, 6'h3F, 5'h1F};
        for (int o = 0; o < 4; o++) begin
            send_operation(tdau_pkg::t_op'(o), zero, zero, 8'd1);
            send_operation(tdau_pkg::t_op'(o), top, top, 8'd255);
            send_operation(tdau_pkg::t_op'(o), zero, top, 8'd7);
            send_operation(tdau_pkg::t_op'(o), full, full, 8'd3);
        end
        send_operation(tdau_pkg::OP_DIV, top, zero, 8'd0);
        send_operation(tdau_pkg::OP_DIV, full, full, 8'd0);
        send_operation(tdau_pkg::OP_ADD, '{10'd1, 6'd0, 6'd0, 5'd0}, top, 8'd0);
        send_operation(tdau_pkg::OP_SUB, zero, '{10'd1, 6'd0, 6'd0, 5'd0}, 8'd0);
        send_operation(tdau_pkg::OP_MID, top, '{10'd1, 6'd0, 6'd0, 5'd0}, 8'd0);
        send_operation(tdau_pkg::OP_DIV, '{10'd999, 6'd1, 6'd1, 5'd1}, zero, 8'd2);
    endtask

    task automatic test_random_operations(int count);
        for (int i = 0; i < count; i++) begin
            send_operation(tdau_pkg::t_op'($urandom_range(0, 3)),
                           any_time($urandom_range(0, 9) != 0),
                           any_time($urandom_range(0, 9) != 0), any_divisor());
        end
    endtask

    task automatic test_output_backpressure();
        -> hold_go;
        test_random_operations(40);
    endtask

    always begin
        @(hold_go);
        hold_output <= 1'b1;
        repeat (80) @(posedge i_clk);
        hold_output <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = $urandom_range(0, 5);
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_wait = $urandom_range(0, 5);
            end
            if (hold_output) begin
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_tod_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_times.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_times.pop_front();
                if (m_axis_tdata[9:0] !== want.ms || m_axis_tdata[15:10] !== want.sec
                    || m_axis_tdata[21:16] !== want.min || m_axis_tdata[26:22] !== want.hr
                    || m_axis_tdata[31:27] !== 5'd0 || m_axis_tuser !== want.err) begin
                    $display("%0t: expected %0d:%0d:%0d.%0d err %0d, got %0d:%0d:%0d.%0d err %0d",
                             $time, want.hr, want.min, want.sec, want.ms, want.err,
                             m_axis_tdata[26:22], m_axis_tdata[21:16], m_axis_tdata[15:10],
                             m_axis_tdata[9:0], m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int waited;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = tdau_pkg::OP_ADD;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_random_operations(450);
        test_output_backpressure();
        test_random_operations(500);
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_times.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_times.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
